>>> rtl/core/rar_pkg.sv
// Shared constants and helpers for the rational arithmetic core.
// No dependencies; used by rar_reduce and rational_arith_reduce_core.
package rar_pkg;

  localparam int WIDTH_DEF = 16;
  localparam int OUT_W     = 33;
  localparam int SIGN_W    = 2;
  localparam int RAW_MAX   = 64;

  // Width of the raw numerator and denominator: exact up to 2*w+1 bits,
  // wrapping modulo 2^64 beyond that.
  function automatic int raw_w(input int w);
    int r;
    r = 2 * w + 1;
    return (r > RAW_MAX) ? RAW_MAX : r;
  endfunction

endpackage

>>> rtl/core/rar_reduce.sv
// Iterative reduction unit: binary GCD of two nonzero magnitudes, then
// restoring division of both magnitudes by that GCD. Uses rar_pkg.
module rar_reduce #(
  parameter int RW = rar_pkg::raw_w(rar_pkg::WIDTH_DEF)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [RW-1:0] mag_n,
  input  logic [RW-1:0] mag_d,
  output logic          done,
  output logic [RW-1:0] quo_n,
  output logic [RW-1:0] quo_d
);

  localparam int KW = $clog2(RW);

  typedef enum logic [2:0] {S_IDLE, S_COMMON, S_XEVEN, S_LOOP, S_DIV} state_t;

  state_t        state;
  logic [RW-1:0] x, y, g, nd, dd, rn, rd;
  logic [KW-1:0] k, cnt;
  logic          x_gt_y;
  logic [RW:0]   trial_n, trial_d;
  logic          take_n, take_d;

  assign x_gt_y  = x > y;
  assign trial_n = {rn, nd[RW-1]};
  assign trial_d = {rd, dd[RW-1]};
  assign take_n  = trial_n >= {1'b0, g};
  assign take_d  = trial_d >= {1'b0, g};
  assign quo_n   = nd;
  assign quo_d   = dd;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      done <= (state == S_DIV) && (cnt == '0);
      unique case (state)
        S_IDLE: begin
          if (start) begin
            x     <= mag_n;
            y     <= mag_d;
            nd    <= mag_n;
            dd    <= mag_d;
            k     <= '0;
            state <= S_COMMON;
          end
        end
        S_COMMON: begin
          if (x[0] | y[0]) begin
            state <= S_XEVEN;
          end else begin
            x <= x >> 1;
            y <= y >> 1;
            k <= k + KW'(1);
          end
        end
        S_XEVEN: begin
          if (x[0]) begin
            state <= S_LOOP;
          end else begin
            x <= x >> 1;
          end
        end
        S_LOOP: begin
          if (y == '0) begin
            g     <= x << k;
            rn    <= '0;
            rd    <= '0;
            cnt   <= KW'(RW - 1);
            state <= S_DIV;
          end else if (!y[0]) begin
            y <= y >> 1;
          end else if (x_gt_y) begin
            x <= y;
            y <= x - y;
          end else begin
            y <= y - x;
          end
        end
        S_DIV: begin
          rn <= take_n ? RW'(trial_n - {1'b0, g}) : trial_n[RW-1:0];
          rd <= take_d ? RW'(trial_d - {1'b0, g}) : trial_d[RW-1:0];
          nd <= {nd[RW-2:0], take_n};
          dd <= {dd[RW-2:0], take_d};
          cnt <= cnt - KW'(1);
          if (cnt == '0) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> rtl/core/rational_arith_reduce_core.sv
// Top level of the rational arithmetic core: operand capture, shared
// multiplier sequence, sign handling and output register. Uses rar_pkg, rar_reduce.
//
// Channel  Dir  Handshake          Payload
// s_*      in   s_tvalid/s_tready  s_tuser: req_type; s_tdata: a_num,a_den,b_num,b_den
// m_*      out  m_tvalid/m_tready  m_tdata: res_num, res_den, sign_out
//
// One word at a time is processed. An arithmetic word runs three products
// through the single shared multiplier, then forms the raw parts, starts the
// reduction unit and waits for its binary GCD and its division of both RW-bit
// magnitudes (RW = 33 at WIDTH 16), then hands the result over. Zero raw
// parts skip the reduction unit; sign requests and unused codes go from
// capture straight to the last state. s_tready is high only while idle. A
// finished result waits in the output register, and a new one waits in the
// last state until m_tready takes the old one. Reset is synchronous.
module rational_arith_reduce_core #(
  parameter int WIDTH = rar_pkg::WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // from bit 0: a_num, a_den, b_num, b_den (WIDTH bits each), zero pad
  input  logic [((4*WIDTH+7)/8)*8-1:0]  s_tdata,
  // req_type
  input  logic [2:0]                    s_tuser,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // from bit 0: res_num (33), res_den (33), sign_out (2), zero pad
  output logic [71:0]                   m_tdata
);

  localparam int RW = rar_pkg::raw_w(WIDTH);
  localparam int OW = rar_pkg::OUT_W;
  localparam int SW = rar_pkg::SIGN_W;

  typedef enum logic [2:0] {OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_SIGN} op_t;
  typedef enum logic [2:0] {S_IDLE, S_MUL, S_SUM, S_RED, S_FIN} state_t;

  state_t                   state;
  logic [2:0]               op;
  logic signed [WIDTH-1:0]  an, ad, bn, bd;
  logic [1:0]               step;
  logic signed [WIDTH-1:0]  ma, mb;
  logic signed [2*WIDTH-1:0] prod;
  logic [RW-1:0]            p0, p1, p2;
  logic [RW-1:0]            sum_num, raw_num, raw_den, mag_n, mag_d;
  logic [RW-1:0]            quo_n, quo_d, fin_n, fin_d;
  logic                     red_start, red_done;
  logic [OW-1:0]            res_num, res_den;
  logic [SW-1:0]            sign_out;

  assign s_tready = (state == S_IDLE);

  // Shared multiplier: step 0 gives the first numerator product, step 1 the
  // cross term, step 2 the denominator product.
  always_comb begin
    case (step)
      2'd0:    begin ma = an; mb = (op == OP_MUL) ? bn : bd; end
      2'd1:    begin ma = bn; mb = ad; end
      default: begin ma = ad; mb = (op == OP_DIV) ? bn : bd; end
    endcase
  end
  assign prod = ma * mb;

  always_comb begin
    case (op)
      OP_ADD:  sum_num = p0 + p1;
      OP_SUB:  sum_num = p0 - p1;
      default: sum_num = p0;
    endcase
  end

  // Magnitudes are unsigned RW-bit values, so the most negative raw value fits.
  assign mag_n = raw_num[RW-1] ? RW'(-raw_num) : raw_num;
  assign mag_d = raw_den[RW-1] ? RW'(-raw_den) : raw_den;
  assign fin_n = raw_num[RW-1] ? RW'(-quo_n) : quo_n;
  assign fin_d = raw_den[RW-1] ? RW'(-quo_d) : quo_d;

  rar_reduce #(.RW(RW)) u_reduce (
    .clk   (clk),
    .rst   (rst),
    .start (red_start),
    .mag_n (mag_n),
    .mag_d (mag_d),
    .done  (red_done),
    .quo_n (quo_n),
    .quo_d (quo_d)
  );

  assign m_tdata = {4'b0, sign_out, res_den, res_num};

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      m_tvalid  <= 1'b0;
      red_start <= 1'b0;
    end else begin
      // The reduction starts only when both raw parts are nonzero.
      red_start <= (state == S_SUM) && (sum_num != '0) && (p2 != '0);
      if (state == S_FIN && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            op    <= s_tuser;
            an    <= s_tdata[WIDTH-1:0];
            ad    <= s_tdata[2*WIDTH-1:WIDTH];
            bn    <= s_tdata[3*WIDTH-1:2*WIDTH];
            bd    <= s_tdata[4*WIDTH-1:3*WIDTH];
            step  <= 2'd0;
            state <= (s_tuser <= 3'(OP_DIV)) ? S_MUL : S_FIN;
          end
        end
        S_MUL: begin
          case (step)
            2'd0:    p0 <= RW'(prod);
            2'd1:    p1 <= RW'(prod);
            default: p2 <= RW'(prod);
          endcase
          step <= step + 2'd1;
          if (step == 2'd2) begin
            state <= S_SUM;
          end
        end
        S_SUM: begin
          raw_num <= sum_num;
          raw_den <= p2;
          if (sum_num == '0 || p2 == '0) begin
            state <= S_FIN;
          end else begin
            state <= S_RED;
          end
        end
        S_RED: begin
          if (red_done) begin
            raw_num <= fin_n;
            raw_den <= fin_d;
            state   <= S_FIN;
          end
        end
        S_FIN: begin
          if (!m_tvalid || m_tready) begin
            sign_out <= (op == 3'(OP_SIGN) && an != '0 && ad != '0) ?
                        ((an[WIDTH-1] ^ ad[WIDTH-1]) ? {SW{1'b1}} : SW'(1)) : '0;
            res_num  <= (op <= 3'(OP_DIV)) ? OW'($signed(raw_num)) : '0;
            // A zero raw part leaves the numerator as is and reports 0 here.
            res_den  <= (op <= 3'(OP_DIV) && raw_num != '0 && raw_den != '0) ?
                        OW'($signed(raw_den)) : '0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> sim/rational_arith_reduce_core_test.sv
// Testbench for rational_arith_reduce_core: fraction arithmetic with GCD reduction.
// Depends on rar_pkg and the core RTL; drives random and directed words, checks results.
`timescale 1ns / 100ps

module rational_arith_reduce_core_test;

  localparam int WIDTH = rar_pkg::WIDTH_DEF;
  localparam int IN_W  = ((4*WIDTH+7)/8)*8;
  localparam int OUT_W = rar_pkg::OUT_W;

  typedef enum logic [2:0] {
    OP_ADD = 3'd0, OP_SUB = 3'd1, OP_MUL = 3'd2, OP_DIV = 3'd3, OP_SIGN = 3'd4,
    OP_RSV5 = 3'd5, OP_RSV6 = 3'd6, OP_RSV7 = 3'd7
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [WIDTH-1:0]  a_num;
    logic [WIDTH-1:0]  a_den;
    logic [WIDTH-1:0]  b_num;
    logic [WIDTH-1:0]  b_den;
  } fraction_req_t;

  typedef struct packed {
    logic [OUT_W-1:0] res_num;
    logic [OUT_W-1:0] res_den;
    logic [1:0]       sign_out;
  } fraction_res_t;

  logic             clk;
  logic             rst;
  logic             s_tvalid;
  logic             s_tready;
  logic [IN_W-1:0]  s_tdata;   // from bit 0: a_num, a_den, b_num, b_den
  logic [2:0]       s_tuser;   // req_type
  logic             m_tvalid;
  logic             m_tready;
  logic [71:0]      m_tdata;   // from bit 0: res_num, res_den, sign_out

  fraction_req_t pending_reqs[$];
  fraction_res_t expected_results[$];

  int  error_count = 0;
  int  cycle_count = 0;
  bit  hold_sender = 0;   // pauses the driver until the core has drained
  bit  quiet_phase = 0;   // no idling at the end of the run
  bit  took_word = 0;     // input word accepted at the last rising edge
  int  send_gap = 0;
  int  sink_gap = 0;

  rational_arith_reduce_core #(.WIDTH(WIDTH)) u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Exact binary GCD on nonzero magnitudes.
  function automatic logic [63:0] gcd_of(input logic [63:0] x, input logic [63:0] y);
    logic [63:0] t;
    int shift;
    shift = 0;
    while (((x | y) & 64'd1) == 0) begin
      x = x >> 1;
      y = y >> 1;
      shift++;
    end
    while (x[0] == 1'b0) x = x >> 1;
    while (y != 0) begin
      while (y[0] == 1'b0) y = y >> 1;
      if (x > y) begin
        t = x; x = y; y = t;
      end
      y = y - x;
    end
    return x << shift;
  endfunction

  function automatic logic [63:0] abs64(input logic [63:0] v);
    return v[63] ? -v : v;
  endfunction

  function automatic logic signed [1:0] sign_of(input logic signed [63:0] v);
    if (v == 0) return 2'sd0;
    return v < 0 ? -2'sd1 : 2'sd1;
  endfunction

  // Works out the reduced fraction (or the sign) for one request.
  function automatic fraction_res_t reduce_fraction(input fraction_req_t r);
    fraction_res_t res;
    logic signed [63:0] an, ad, bn, bd, num, den;
    logic [63:0] mn, md, g, q;
    logic signed [1:0] sg;
    an = 64'(signed'(r.a_num));
    ad = 64'(signed'(r.a_den));
    bn = 64'(signed'(r.b_num));
    bd = 64'(signed'(r.b_den));
    num = 0;
    den = 0;
    sg  = 0;
    case (r.op)
      OP_ADD:  begin num = an*bd + bn*ad; den = ad*bd; end
      OP_SUB:  begin num = an*bd - bn*ad; den = ad*bd; end
      OP_MUL:  begin num = an*bn;         den = ad*bd; end
      OP_DIV:  begin num = an*bd;         den = ad*bn; end
      OP_SIGN: sg = sign_of(an) * sign_of(ad);
      default: ;
    endcase
    if (r.op <= OP_DIV) begin
      mn = abs64(num);
      md = abs64(den);
      if (mn == 0 || md == 0) begin
        den = 0;
      end else begin
        g = gcd_of(mn, md);
        q = mn / g;
        num = num[63] ? -q : q;
        q = md / g;
        den = den[63] ? -q : q;
      end
    end
    res.res_num  = num[OUT_W-1:0];
    res.res_den  = den[OUT_W-1:0];
    res.sign_out = sg;
    return res;
  endfunction

  // Random field value weighted toward extremes, small values and common factors.
  function automatic logic [WIDTH-1:0] pick_field();
    case ($urandom_range(0, 9))
      0: return {1'b1, {(WIDTH-1){1'b0}}};
      1: return {1'b0, {(WIDTH-1){1'b1}}};
      2: return '0;
      3: return WIDTH'(signed'(-($urandom_range(1, 16))));
      4, 5: return WIDTH'($urandom_range(1, 24));
      6: return WIDTH'($urandom_range(1, 300) * 60);
      default: return WIDTH'($urandom);
    endcase
  endfunction

  function automatic fraction_req_t random_req(input bit any_op);
    fraction_req_t r;
    r.op    = any_op ? op_t'($urandom_range(0, 7)) : op_t'($urandom_range(0, 4));
    r.a_num = pick_field();
    r.a_den = pick_field();
    r.b_num = pick_field();
    r.b_den = pick_field();
    return r;
  endfunction

  task automatic add_req(input op_t op, input int an, input int ad, input int bn, input int bd);
    fraction_req_t r;
    r.op = op;
    r.a_num = WIDTH'(an);
    r.a_den = WIDTH'(ad);
    r.b_num = WIDTH'(bn);
    r.b_den = WIDTH'(bd);
    pending_reqs.push_back(r);
  endtask

  // Records whether the offered word was taken at this rising edge.
  always @(posedge clk) begin
    took_word <= !rst && s_tvalid && s_tready;
  end

  // Driver: offers the head of the queue, with random bursts of idle cycles.
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (s_tvalid && !took_word) begin
      // Word still waiting for acceptance; keep it on the bus.
    end else begin
      if (s_tvalid) void'(pending_reqs.pop_front());
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        s_tvalid <= 1'b0;
      end else if (pending_reqs.size() == 0 || hold_sender) begin
        s_tvalid <= 1'b0;
      end else if (!quiet_phase && $urandom_range(0, 9) == 0) begin
        send_gap <= $urandom_range(0, 4);
        s_tvalid <= 1'b0;
      end else begin
        s_tvalid <= 1'b1;
        s_tuser  <= pending_reqs[0].op;
        s_tdata  <= IN_W'({pending_reqs[0].b_den, pending_reqs[0].b_num,
                           pending_reqs[0].a_den, pending_reqs[0].a_num});
      end
    end
  end

  // Sink backpressure in bursts.
  always @(negedge clk) begin
    if (rst || quiet_phase) begin
      m_tready <= 1'b1;
    end else if (sink_gap > 0) begin
      sink_gap <= sink_gap - 1;
      m_tready <= 1'b0;
    end else if ($urandom_range(0, 7) == 0) begin
      sink_gap <= $urandom_range(0, 4);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // Monitor: predicts on input acceptance, checks on output acceptance.
  always @(posedge clk) begin
    fraction_req_t r;
    fraction_res_t got, want;
    cycle_count <= cycle_count + 1;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        r.op    = op_t'(s_tuser);
        r.a_num = s_tdata[0*WIDTH +: WIDTH];
        r.a_den = s_tdata[1*WIDTH +: WIDTH];
        r.b_num = s_tdata[2*WIDTH +: WIDTH];
        r.b_den = s_tdata[3*WIDTH +: WIDTH];
        expected_results.push_back(reduce_fraction(r));
      end
      if (m_tvalid && m_tready) begin
        got.res_num  = m_tdata[0 +: OUT_W];
        got.res_den  = m_tdata[OUT_W +: OUT_W];
        got.sign_out = m_tdata[2*OUT_W +: 2];
        if (expected_results.size() == 0) begin
          $error("result word with nothing expected: %h", m_tdata);
          error_count++;
        end else begin
          want = expected_results.pop_front();
          if (got.res_num !== want.res_num) begin
            $error("res_num expected %h actual %h", want.res_num, got.res_num);
            error_count++;
          end
          if (got.res_den !== want.res_den) begin
            $error("res_den expected %h actual %h", want.res_den, got.res_den);
            error_count++;
          end
          if (got.sign_out !== want.sign_out) begin
            $error("sign_out expected %h actual %h", want.sign_out, got.sign_out);
            error_count++;
          end
        end
      end
    end
  end

  // Watchdog: ends the run with the error message once the cycle count passes its limit.
  always @(posedge clk) begin
    if (cycle_count > 2000000) begin
      $display("rational_arith_reduce_core_test: done, errors");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = '0;
    m_tready = 1'b1;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed words: every operation, extreme operands, zero results,
    // division by a zero fraction, sign requests and the unused codes.
    add_req(OP_ADD, 1, 2, 1, 3);
    add_req(OP_SUB, 1, 2, 1, 2);
    add_req(OP_MUL, -4, 6, 3, -8);
    add_req(OP_DIV, 2, 3, 0, 5);
    add_req(OP_DIV, 2, 3, 4, 9);
    add_req(OP_ADD, -32768, -32768, -32768, -32768);
    add_req(OP_SUB, 32767, -32768, -32768, 32767);
    add_req(OP_MUL, -32768, 1, -32768, 1);
    add_req(OP_DIV, -32768, 32767, 32767, -32768);
    add_req(OP_ADD, 5, 0, 3, 7);
    add_req(OP_MUL, 0, 0, 0, 0);
    add_req(OP_SIGN, -5, 3, 0, 0);
    add_req(OP_SIGN, -32768, -32768, 1, 1);
    add_req(OP_SIGN, 0, 7, 2, 2);
    add_req(OP_SIGN, 32767, 0, -1, -1);
    add_req(OP_RSV5, 1, 2, 3, 4);
    add_req(OP_RSV6, -1, -1, -1, -1);
    add_req(OP_RSV7, 32767, 32767, 32767, 32767);
    add_req(OP_SUB, 6, 4, 3, 2);
    add_req(OP_ADD, 7, -9, -7, 9);

    wait (pending_reqs.size() == 0);
    // Let the sender pause until the core has returned everything.
    hold_sender = 1'b1;
    wait (expected_results.size() == 0);
    hold_sender = 1'b0;

    for (int i = 0; i < 850; i++) begin
      pending_reqs.push_back(random_req($urandom_range(0, 15) == 0));
      if (i == 700) begin
        wait (pending_reqs.size() == 0);
        quiet_phase = 1'b1;
      end
    end
    wait (pending_reqs.size() == 0 && !s_tvalid);
    wait (expected_results.size() == 0);
    repeat (200) @(posedge clk);

    if (error_count == 0 && expected_results.size() == 0) begin
      $display("rational_arith_reduce_core_test: done, clean");
    end else begin
      $display("rational_arith_reduce_core_test: done, errors");
    end
    $finish;
  end

endmodule
